FILE: design/tse_pkg.sv
// Package for the Taylor sine evaluator.
// Holds widths, constants and the pipeline item type; used by every module.
package tse_pkg;

    localparam int AngleW      = 32;
    localparam int OutW        = 48;
    localparam int TcW         = 5;
    localparam int NW          = 6;
    localparam int GW          = 41;
    localparam int RW          = 30;
    localparam int TW          = 46;
    localparam int GSplit      = 20;
    localparam int TSplit      = 23;
    localparam int DefMaxTerms = 16;

    localparam logic [TcW-1:0]    TcReset  = TcW'(8);
    localparam logic [AngleW-1:0] TwoPiQ26 = AngleW'(421657428);

    typedef struct packed {
        logic signed [GW-1:0]   g;
        logic signed [RW-1:0]   r;
        logic signed [OutW-1:0] sum;
        logic [NW-1:0]          n;
    } item_t;

endpackage

FILE: design/taylor_sine_evaluator_unit.sv
// Taylor sine evaluator top level: reduction, then one step unit per series index.
// Throughput one transaction per cycle while m_tready stays high.
// Each stage has its own valid bit and collapses bubbles under backpressure.
// Reset (rst_n, async, active low) empties the pipeline and sets term_count to 8.
// Depends on tse_pkg, tse_reduce and tse_term.
module taylor_sine_evaluator_unit #(
    parameter int MAX_TERMS = tse_pkg::DefMaxTerms
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tse_pkg::TcW-1:0]       cfg_data,    // term_count
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tse_pkg::AngleW-1:0]    s_tdata,     // [31:0] angle
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tse_pkg::OutW-1:0]      m_tdata      // [47:0] sine_value
);
    import tse_pkg::*;

    localparam int Steps = 2 * MAX_TERMS - 1;

    logic [TcW-1:0] term_count_reg;
    logic  [Steps:0] v;
    logic  [Steps:0] rdy;
    item_t           it [Steps+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            term_count_reg <= TcReset;
        else if (cfg_valid)
            term_count_reg <= cfg_data;
    end

    tse_reduce #(
        .MAX_TERMS (MAX_TERMS)
    ) u_reduce (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .angle      ($signed(s_tdata)),
        .term_count (term_count_reg),
        .out_valid  (v[0]),
        .out_ready  (rdy[0]),
        .out_item   (it[0])
    );

    for (genvar k = 1; k <= Steps; k++)
    begin : g_step
        tse_term #(
            .J (k)
        ) u_term (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v[k-1]),
            .in_ready  (rdy[k-1]),
            .in_item   (it[k-1]),
            .out_valid (v[k]),
            .out_ready (rdy[k]),
            .out_item  (it[k])
        );
    end

    assign rdy[Steps] = m_tready;
    assign m_tvalid   = v[Steps];
    assign m_tdata    = it[Steps].sum;

endmodule

FILE: design/tse_reduce.sv
// Angle reduction: truncating remainder against 2*pi in Q6.26, three stages.
// Depends on tse_pkg.
module tse_reduce #(
    parameter int MAX_TERMS = tse_pkg::DefMaxTerms
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [tse_pkg::AngleW-1:0] angle,
    input  logic [tse_pkg::TcW-1:0]           term_count,
    output logic                              out_valid,
    input  logic                              out_ready,
    output tse_pkg::item_t                    out_item
);
    import tse_pkg::*;

    localparam logic [AngleW-1:0] C1 = TwoPiQ26;
    localparam logic [AngleW-1:0] C2 = AngleW'(2 * 421657428);
    localparam logic [AngleW-1:0] C4 = AngleW'(4 * 421657428);

    logic              v1_reg, v2_reg, v3_reg;
    logic              rdy1, rdy2, rdy3;
    logic [AngleW-1:0] a1_reg, a2_reg;
    logic              neg1_reg, neg2_reg;
    logic [NW-1:0]     n1_reg, n2_reg;
    item_t             item3_reg;

    logic [AngleW-1:0] abs_next, a_step, a2_next, a3;
    logic [NW-1:0]     n_next;
    logic signed [RW-1:0] r_next;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb
    begin
        abs_next = angle[AngleW-1] ? AngleW'(-angle) : AngleW'(angle);
        n_next   = (int'(term_count) > MAX_TERMS) ? NW'(MAX_TERMS) : NW'(term_count);
        a_step   = (a1_reg >= C4) ? a1_reg - C4 : a1_reg;
        a2_next  = (a_step >= C2) ? a_step - C2 : a_step;
        a3       = (a2_reg >= C1) ? a2_reg - C1 : a2_reg;
        r_next   = neg2_reg ? -$signed(RW'(a3)) : $signed(RW'(a3));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            a1_reg   <= abs_next;
            neg1_reg <= angle[AngleW-1];
            n1_reg   <= n_next;
        end
        if (rdy2)
        begin
            a2_reg   <= a2_next;
            neg2_reg <= neg1_reg;
            n2_reg   <= n1_reg;
        end
        if (rdy3)
        begin
            item3_reg.g   <= GW'(64'h1_0000_0000);
            item3_reg.r   <= r_next;
            item3_reg.sum <= '0;
            item3_reg.n   <= n2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_item  = item3_reg;

endmodule

FILE: design/tse_term.sv
// One step of the running product, g = g*r/2^26 * (1/J); odd steps for terms below
// n update the sum by +/-g. Four stages, split multiplies. Depends on tse_pkg.
module tse_term #(
    parameter int J = 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  tse_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output tse_pkg::item_t out_item
);
    import tse_pkg::*;

    localparam longint Recip  = ((longint'(1) <<< 32) + J / 2) / J;
    localparam int     TermI  = (J - 1) / 2;
    localparam bit     IsOdd  = (J % 2) == 1;
    localparam bit     NegAdd = (TermI % 2) == 1;
    localparam bit     Bypass = (J == 1);
    localparam int     PW1    = GW - GSplit + RW;
    localparam int     PW2    = TW - TSplit + 33;
    localparam int     PW3    = TSplit + 1 + 33;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;
    item_t it1_reg, it2_reg, it3_reg, it4_reg;
    logic signed [PW1-1:0] ph1_reg, pl1_reg;
    logic signed [TW-1:0]  t2_reg, t3_reg;
    logic signed [PW2-1:0] ph3_reg;
    logic signed [PW3-1:0] pl3_reg;

    logic signed [32:0]        recip_v;
    logic signed [GW+RW-1:0]   prod1;
    logic signed [TW+32:0]     prod2;
    logic signed [GW-1:0]      g_next;
    logic signed [OutW+1:0]    sum_wide;
    item_t                     it4_next;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;
    assign recip_v  = 33'(Recip);

    always_comb
    begin
        prod1  = ((GW+RW)'(ph1_reg) <<< GSplit) + (GW+RW)'(pl1_reg);
        prod2  = ((TW+33)'(ph3_reg) <<< TSplit) + (TW+33)'(pl3_reg);
        g_next = Bypass ? GW'(t3_reg) : GW'(prod2 >>> 32);
        it4_next   = it3_reg;
        it4_next.g = g_next;
        sum_wide   = (OutW+2)'(it3_reg.sum);
        if (IsOdd && (it3_reg.n > NW'(TermI)))
        begin
            if (NegAdd)
                sum_wide = sum_wide - (OutW+2)'(g_next);
            else
                sum_wide = sum_wide + (OutW+2)'(g_next);
        end
        if (sum_wide > $signed((OutW+2)'({1'b0, {(OutW-1){1'b1}}})))
            it4_next.sum = {1'b0, {(OutW-1){1'b1}}};
        else if (sum_wide < -$signed((OutW+2)'({1'b1, {(OutW-1){1'b0}}})))
            it4_next.sum = {1'b1, {(OutW-1){1'b0}}};
        else
            it4_next.sum = OutW'(sum_wide);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            it1_reg <= in_item;
            ph1_reg <= $signed(in_item.g[GW-1:GSplit]) * in_item.r;
            pl1_reg <= $signed({1'b0, in_item.g[GSplit-1:0]}) * in_item.r;
        end
        if (rdy2)
        begin
            it2_reg <= it1_reg;
            t2_reg  <= TW'(prod1 >>> 26);
        end
        if (rdy3)
        begin
            it3_reg <= it2_reg;
            t3_reg  <= t2_reg;
            ph3_reg <= $signed(t2_reg[TW-1:TSplit]) * recip_v;
            pl3_reg <= $signed({1'b0, t2_reg[TSplit-1:0]}) * recip_v;
        end
        if (rdy4)
            it4_reg <= it4_next;
    end

    assign out_valid = v4_reg;
    assign out_item  = it4_reg;

endmodule

FILE: dv/taylor_sine_evaluator_checker.sv
// Checker for the Taylor sine evaluator: watches the angle, sine and term_count channels,
// computes the expected series sum per angle and compares it with each sine transaction.
// Depends on tse_pkg for the port widths and constants.
module taylor_sine_evaluator_checker
    import tse_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [TcW-1:0]      cfg_data,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [AngleW-1:0]   s_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [OutW-1:0]     m_tdata,
    output int                  errors,
    output int                  pending,
    output int                  checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [TcW-1:0]  terms_q;
    logic [OutW-1:0] sine_q[$];

    // floor(a*b / 2^k) on exact wide signed arithmetic
    function automatic longint floor_mul(longint a, longint b, int k);
        logic signed [127:0] p;
        p = 128'(signed'(a)) * 128'(signed'(b));
        p = p >>> k;
        return longint'(p);
    endfunction

    function automatic logic [OutW-1:0] series_sine(logic [AngleW-1:0] raw, logic [TcW-1:0] tc);
        longint ang, r, g, sum, recip, lim;
        int n;
        ang = longint'(signed'(raw));
        r = ang % 64'sd421657428;
        n = (tc > DefMaxTerms) ? DefMaxTerms : int'(tc);
        g = 64'sd1 <<< 32;
        sum = 0;
        lim = (64'sd1 <<< 47) - 1;
        for (int j = 1; j <= 2 * n - 1; j++)
        begin
            recip = ((64'sd1 <<< 32) + j / 2) / j;
            g = floor_mul(g, r, 26);
            g = floor_mul(g, recip, 32);
            if (j % 2 == 1)
            begin
                if (((j - 1) / 2) % 2 == 1)
                    sum = sum - g;
                else
                    sum = sum + g;
                if (sum > lim)
                    sum = lim;
                if (sum < -lim - 1)
                    sum = -lim - 1;
            end
        end
        return sum[OutW-1:0];
    endfunction

    assign pending = sine_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            terms_q <= TcReset;
            errors  <= 0;
            checked <= 0;
            sine_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                terms_q <= cfg_data;
            if (s_tvalid && s_tready)
                sine_q.push_back(series_sine(s_tdata, terms_q));
            if (m_tvalid && m_tready)
            begin
                checked <= checked + 1;
                if (sine_q.size() == 0)
                begin
                    $error("unexpected sine_value actual %0h", m_tdata);
                    errors <= errors + 1;
                end
                else if (sine_q[0] !== m_tdata)
                begin
                    $error("sine_value expected %0h actual %0h", sine_q[0], m_tdata);
                    errors <= errors + 1;
                    void'(sine_q.pop_front());
                end
                else
                    void'(sine_q.pop_front());
            end
        end
    end
endmodule

FILE: dv/taylor_sine_evaluator_unit_tb.sv
// Testbench top for the Taylor sine evaluator: clock, reset, angle and term_count stimulus
// with random idling, and the verdict. Depends on tse_pkg, the evaluator unit and the checker module.
module taylor_sine_evaluator_unit_tb;
    import tse_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Latency = 127;
    localparam longint Limit = 2000000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [TcW-1:0]     cfg_data = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [AngleW-1:0]  s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OutW-1:0]    m_tdata;
    int                 errors, pending, checked;
    longint             cycles = 0;
    bit                 calm = 1'b0;
    int                 sent = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    taylor_sine_evaluator_unit i_dut (.*);

    taylor_sine_evaluator_checker i_chk (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > Limit)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // sink: random stall bursts, none once calm
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            m_tready <= 1'b1;
            n = $urandom_range(1, 40);
            repeat (n) @(posedge clk);
            if (!calm && $urandom_range(0, 1))
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    task automatic send_angle(logic [AngleW-1:0] a);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= a;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
    endtask

    task automatic set_terms(logic [TcW-1:0] tc);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (Latency + 8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= tc;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [AngleW-1:0] pick_angle();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return AngleW'($signed($urandom_range(0, 421657427 * 2)) - 421657427);
            2: return AngleW'(421657428 * $urandom_range(0, 5)) ^ AngleW'($urandom_range(0, 3));
            default: return AngleW'($signed($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    initial
    begin
        logic [TcW-1:0] tcs[6] = '{5'd8, 5'd0, 5'd1, 5'd16, 5'd31, 5'd5};
        logic [AngleW-1:0] dir[14] = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff,
            32'h1, 32'd421657428, -32'sd421657428, 32'd421657427, 32'd105414357,
            -32'sd105414357, 32'd210828714, 32'haaaaaaaa, 32'h55555555, 32'd67108864};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (tcs[p])
        begin
            if (p > 0)
                set_terms(tcs[p]);
            foreach (dir[k])
                send_angle(dir[k]);
            repeat (p == 0 ? 60 : 100)
                send_angle(pick_angle());
        end
        set_terms(5'($urandom_range(0, 31)));
        repeat (150)
            send_angle(pick_angle());
        calm = 1'b1;
        repeat (100)
            send_angle(pick_angle());
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (Latency + 8) @(posedge clk);
        $display("Sent %0d angles over seven term_count settings including 0, 16 and 31;", sent);
        $display("%0d sine transactions checked.", checked);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

FILE: sim.f
design/tse_pkg.sv
design/tse_reduce.sv
design/tse_term.sv
design/taylor_sine_evaluator_unit.sv
dv/taylor_sine_evaluator_checker.sv
dv/taylor_sine_evaluator_unit_tb.sv
